// ===== src/sld_pkg.sv =====
`timescale 1ns / 1ps

package sld_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'h1F;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_TYPE    = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_GARBAGE = 3'd0,
    ROLE_SYNC    = 3'd1,
    ROLE_TYPE    = 3'd2,
    ROLE_LEN_HI  = 3'd3,
    ROLE_LEN_LO  = 3'd4,
    ROLE_PAYLOAD = 3'd5
  } role_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    role_t       byte_role;
    logic [7:0]  frame_type;
    logic [15:0] payload_length;
    logic        frame_end;
  } result_t;

endpackage

// ===== src/sld_fsm.sv =====
`timescale 1ns / 1ps

module sld_fsm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  output sld_pkg::result_t    result
);
  import sld_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [15:0] len_lo_val;

  assign len_lo_val = {len_r[15:8], rx_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      type_r   <= '0;
      len_r    <= '0;
      remain_r <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      type_r   <= type_nxt;
      len_r    <= len_nxt;
      remain_r <= remain_nxt;
    end
  end

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    remain_nxt = remain_r;
    unique case (phase_r)
      PH_TYPE: begin
        type_nxt  = rx_byte;
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_nxt   = {rx_byte, 8'h00};
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_nxt    = len_lo_val;
        remain_nxt = len_lo_val;
        phase_nxt  = (len_lo_val == 16'd0) ? PH_HUNT : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (remain_r <= 16'd1) begin
          remain_nxt = '0;
          phase_nxt  = PH_HUNT;
        end else begin
          remain_nxt = remain_r - 16'd1;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (rx_byte == SYNC_BYTE) begin
          type_nxt   = '0;
          len_nxt    = '0;
          remain_nxt = '0;
          phase_nxt  = PH_TYPE;
        end
      end
    endcase
  end

  // result
  always_comb begin
    result                = '0;
    result.byte_out       = rx_byte;
    result.byte_role      = ROLE_GARBAGE;
    unique case (phase_r)
      PH_TYPE: begin
        result.byte_role  = ROLE_TYPE;
        result.frame_type = rx_byte;
      end
      PH_LEN_HI: begin
        result.byte_role  = ROLE_LEN_HI;
        result.frame_type = type_r;
      end
      PH_LEN_LO: begin
        result.byte_role      = ROLE_LEN_LO;
        result.frame_type     = type_r;
        result.payload_length = len_lo_val;
        result.frame_end      = (len_lo_val == 16'd0);
      end
      PH_PAYLOAD: begin
        result.byte_role      = ROLE_PAYLOAD;
        result.frame_type     = type_r;
        result.payload_length = len_r;
        result.frame_end      = (remain_r <= 16'd1);
      end
      default: begin
        if (rx_byte == SYNC_BYTE) begin
          result.byte_role = ROLE_SYNC;
        end
      end
    endcase
  end

endmodule

// ===== src/sld_out_reg.sv =====
`timescale 1ns / 1ps

module sld_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  sld_pkg::result_t result,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             can_load,
  output sld_pkg::result_t held
);
  import sld_pkg::*;

  logic    valid_r;
  result_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign held      = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

endmodule

// ===== src/sync_length_frame_deframer.sv =====
`timescale 1ns / 1ps

// Frame delimiter for a byte stream framed as sync byte 0x1F, type byte,
// 16-bit big-endian payload length and payload. Every accepted byte yields
// exactly one registered result beat in the next cycle, tagging the byte's
// role, the frame type and length once known, and frame end. Throughput is
// one byte per cycle: the role/phase update is a single pass of logic into
// the output register, and a new byte is taken whenever that register is
// empty or being drained in the same cycle.
module sync_length_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte_out,
  output logic [2:0]  out_byte_role,
  output logic [7:0]  out_frame_type,
  output logic [15:0] out_payload_length,
  output logic        out_frame_end
);
  import sld_pkg::*;

  logic    accept;
  result_t fsm_res;
  result_t held;

  assign accept = in_valid && in_ready;

  sld_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (accept),
    .rx_byte (in_rx_byte),
    .result  (fsm_res)
  );

  sld_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .result    (fsm_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (in_ready),
    .held      (held)
  );

  assign out_byte_out       = held.byte_out;
  assign out_byte_role      = held.byte_role;
  assign out_frame_type     = held.frame_type;
  assign out_payload_length = held.payload_length;
  assign out_frame_end      = held.frame_end;

`ifndef SYNTHESIS
  a_end_role: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |->
      (out_byte_role == ROLE_LEN_LO || out_byte_role == ROLE_PAYLOAD))
    else $error("frame end on a byte outside length low or payload");

  a_garbage_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_byte_role == ROLE_GARBAGE || out_byte_role == ROLE_SYNC)) |->
      (out_frame_type == 8'd0 && out_payload_length == 16'd0 && !out_frame_end))
    else $error("garbage or sync beat carries frame info");

  a_len_lo_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_byte_role == ROLE_LEN_LO) |->
      (out_frame_end == (out_payload_length == 16'd0)))
    else $error("length low end flag does not match zero length");

  a_sync_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_byte_role == ROLE_SYNC) |-> (out_byte_out == SYNC_BYTE))
    else $error("sync role on a non-sync byte");
`endif

endmodule
